// ===== hdl/fat16rsp_pkg.sv =====
// shared types and constants for the fat16 read segment planner
// used by fat16_read_segment_planner and the testbench, no dependencies
package fat16rsp_pkg;

   localparam logic [15:0] END_MARK = 16'hfff7;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_SKIP  = 2'd1;
   localparam logic [1:0] ERR_BAD   = 2'd2;
   localparam logic [1:0] ERR_TRUNC = 2'd3;

   localparam logic [2:0] CSR_BPS  = 3'd0;
   localparam logic [2:0] CSR_SPC  = 3'd1;
   localparam logic [2:0] CSR_RSV  = 3'd2;
   localparam logic [2:0] CSR_COPY = 3'd3;
   localparam logic [2:0] CSR_SPT  = 3'd4;
   localparam logic [2:0] CSR_ROOT = 3'd5;

   localparam logic [1:0] PH_FWD  = 2'd0;
   localparam logic [1:0] PH_MEAS = 2'd1;
   localparam logic [1:0] PH_REM  = 2'd2;
   localparam logic [1:0] PH_SEG  = 2'd3;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b00000000001,
      S_SETUP = 11'b00000000010,
      S_DIV   = 11'b00000000100,
      S_SKIP  = 11'b00000001000,
      S_HOPW  = 11'b00000010000,
      S_SEG   = 11'b00000100000,
      S_CHK   = 11'b00001000000,
      S_ADDR  = 11'b00010000000,
      S_NEW   = 11'b00100000000,
      S_ERR2  = 11'b01000000000,
      S_PUSH  = 11'b10000000000
   } state_type;

   typedef struct packed {
      logic [31:0] vo;
      logic [31:0] bo;
      logic [19:0] len;
      logic [31:0] tot;
      logic        last;
      logic [1:0]  err;
   } seg_type;

endpackage

// ===== hdl/fat16rsp_div.sv =====
// radix-2 restoring divider, one quotient bit per cycle, 32-bit dividend
// by 20-bit divisor; uses nothing from the package
module fat16rsp_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [19:0] divisor,
   output logic        done,
   output logic [31:0] quotient,
   output logic [19:0] remainder
);

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] quo_ff, quo_in;
   logic [19:0] rem_ff, rem_in;
   logic [19:0] d_ff, d_in;
   logic [20:0] trial;
   logic [20:0] diff;
   logic        ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[31]};
      diff    = trial - {1'b0, d_ff};
      ge      = trial >= {1'b0, d_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         quo_in = dividend;
         rem_in = '0;
         d_in   = divisor;
      end else if (run_ff) begin
         quo_in = {quo_ff[30:0], ge};
         rem_in = ge ? diff[19:0] : trial[19:0];
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== hdl/fat16_read_segment_planner.sv =====
// top level of the fat16 read segment planner: table memory, sequencer, shared
// multiplier; depends on fat16rsp_pkg and fat16rsp_div
//
// usage: a req word with req_tuser = 0 writes one allocation table entry and
// gives no rsp word. a req word with req_tuser = 1 is a read request; it yields
// one or more rsp words, the final one with rsp_tlast high, rsp_tuser carrying
// the error code. req_tready is high only while the sequencer is idle, so one
// read is worked at a time. a read first runs the setup multiplier steps, then
// a bit-serial divide of the position by the cluster size, then one table memory
// read per link walked. a skip that exceeds the table size also walks the chain
// cycle once to measure it and divides the surplus by its length. each emitted
// segment then takes a link hop (not for the first), a cluster check, an address
// multiply and a push. the single table read port and the serial divider set
// the pace.
// a stalled rsp side holds the sequencer at its next output word; the output
// register keeps its word until taken. reset restores the register defaults
// and the idle state; table contents are undefined until written.
module fat16_read_segment_planner #(
   parameter int TABLE_ENTRIES = 4096,
   parameter int MAX_SEGMENTS  = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // table_index, table_value, start_cluster, byte_position, byte_count
   input  logic [111:0] req_tdata,
   // func
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // volume_offset, buffer_offset, seg_length, total_read
   output logic [119:0] rsp_tdata,
   // error
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);
   import fat16rsp_pkg::*;

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam int TW = $clog2(TABLE_ENTRIES) + 1;
   localparam int NW = $clog2(MAX_SEGMENTS + 1);
   localparam logic [16:0] TE17 = 17'(TABLE_ENTRIES);

   logic [12:0] bps_ff;
   logic [7:0]  spc_ff;
   logic [15:0] rsv_ff;
   logic [2:0]  copy_ff;
   logic [15:0] spt_ff;
   logic [15:0] root_ff;

   logic [12:0] bps_c;
   logic [7:0]  spc_c;
   logic [2:0]  copy_c;
   logic [15:0] spt_c;

   state_type   st_ff, st_in, ret_ff, ret_in;
   logic [1:0]  ph_ff, ph_in;
   logic [2:0]  step_ff, step_in;
   logic [19:0] cs_ff, cs_in;
   logic [31:0] base_ff, base_in;
   logic [31:0] p_ff, p_in;
   logic [15:0] cur_ff, cur_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] count_ff, count_in;
   logic [19:0] off_ff, off_in;
   logic [TW-1:0] cnt_ff, cnt_in;
   logic [TW-1:0] len_ff, len_in;
   logic [15:0] mark_ff, mark_in;
   logic [31:0] done_ff, done_in;
   logic [31:0] size_ff, size_in;
   logic [NW-1:0] n_ff, n_in;
   logic        hop_ff, hop_in;
   logic        pv_ff, pv_in;
   seg_type     pend_ff, pend_in;
   seg_type     out_ff;
   logic        ov_ff, ov_in;

   logic [15:0] tbl_mem [TABLE_ENTRIES];
   logic [15:0] rd_q_ff;
   logic        tbl_we;
   logic [16:0] widx;

   logic        mul_en;
   logic [31:0] mul_a;
   logic [19:0] mul_b;
   logic [51:0] prod;

   logic        div_go, div_done;
   logic [31:0] div_a, div_quo;
   logic [19:0] div_b, div_rem;

   logic        push;
   logic        cur_ok;
   logic [TW-1:0] len_nx;
   logic [31:0] room;
   logic [19:0] clen;
   logic [19:0] slen;
   logic        accept;

   assign bps_c  = (bps_ff == 13'd0) ? 13'd1 : ((bps_ff > 13'd4096) ? 13'd4096 : bps_ff);
   assign spc_c  = (spc_ff == 8'd0) ? 8'd1 : ((spc_ff > 8'd128) ? 8'd128 : spc_ff);
   assign copy_c = (copy_ff == 3'd0) ? 3'd1 : ((copy_ff > 3'd4) ? 3'd4 : copy_ff);
   assign spt_c  = (spt_ff == 16'd0) ? 16'd1 : spt_ff;

   assign accept = req_tvalid && req_tready;
   assign widx   = 17'(req_tdata[11:0]);
   assign tbl_we = accept && (req_tuser[0] == FUNC_WRITE) && (widx < TE17);
   assign cur_ok = {1'b0, cur_ff} < TE17;
   assign len_nx = len_ff + TW'(1);
   assign room   = size_ff - done_ff;
   assign clen   = cs_ff - off_ff;
   assign slen   = (32'(clen) > room) ? room[19:0] : clen;
   assign prod   = mul_a * mul_b;

   fat16rsp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_go),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      st_in    = st_ff;
      ret_in   = ret_ff;
      ph_in    = ph_ff;
      step_in  = step_ff;
      cs_in    = cs_ff;
      base_in  = base_ff;
      p_in     = p_ff;
      cur_in   = cur_ff;
      pos_in   = pos_ff;
      count_in = count_ff;
      off_in   = off_ff;
      cnt_in   = cnt_ff;
      len_in   = len_ff;
      mark_in  = mark_ff;
      done_in  = done_ff;
      size_in  = size_ff;
      n_in     = n_ff;
      hop_in   = hop_ff;
      pv_in    = pv_ff;
      pend_in  = pend_ff;
      mul_en   = 1'b0;
      mul_a    = '0;
      mul_b    = '0;
      div_go   = 1'b0;
      div_a    = '0;
      div_b    = '0;
      push     = 1'b0;
      unique case (st_ff)
         S_IDLE: begin
            if (accept && (req_tuser[0] == FUNC_READ)) begin
               cur_in  = req_tdata[43:28];
               pos_in  = req_tdata[75:44];
               size_in = req_tdata[107:76];
               step_in = '0;
               st_in   = S_SETUP;
            end
         end
         S_SETUP: begin
            mul_en  = 1'b1;
            step_in = step_ff + 3'd1;
            case (step_ff)
               3'd0: begin
                  mul_a = 32'(bps_c);
                  mul_b = 20'(spc_c);
               end
               3'd1: begin
                  cs_in = p_ff[19:0];
                  mul_a = 32'(rsv_ff);
                  mul_b = 20'(bps_c);
               end
               3'd2: begin
                  base_in = p_ff;
                  mul_a   = 32'(copy_c);
                  mul_b   = 20'(spt_c);
               end
               3'd3: begin
                  mul_a = p_ff;
                  mul_b = 20'(bps_c);
               end
               default: begin
                  mul_en  = 1'b0;
                  base_in = base_ff + p_ff + {11'd0, root_ff, 5'd0};
                  div_go  = 1'b1;
                  div_a   = pos_ff;
                  div_b   = cs_ff;
                  ph_in   = PH_FWD;
                  st_in   = S_DIV;
               end
            endcase
         end
         S_DIV: begin
            if (div_done) begin
               if (ph_ff == PH_MEAS) begin
                  cnt_in = TW'(div_rem);
                  ph_in  = PH_REM;
               end else begin
                  count_in = div_quo;
                  off_in   = div_rem;
                  cnt_in   = (div_quo > 32'(TABLE_ENTRIES)) ? TW'(TABLE_ENTRIES)
                                                             : div_quo[TW-1:0];
               end
               st_in = S_SKIP;
            end
         end
         S_SKIP: begin
            if (ph_ff == PH_MEAS) begin
               st_in = S_HOPW;
            end else if (cnt_ff != '0) begin
               st_in = S_HOPW;
            end else if ((ph_ff == PH_FWD) && (count_ff > 32'(TABLE_ENTRIES))) begin
               mark_in = cur_ff;
               len_in  = '0;
               ph_in   = PH_MEAS;
            end else begin
               done_in = '0;
               n_in    = '0;
               hop_in  = 1'b0;
               pv_in   = 1'b0;
               ph_in   = PH_SEG;
               st_in   = S_SEG;
            end
         end
         S_HOPW: begin
            if (!cur_ok) begin
               if (ph_ff == PH_SEG) begin
                  st_in = S_ERR2;
               end else begin
                  pend_in = '{vo: '0, bo: '0, len: '0, tot: '0, last: 1'b1, err: ERR_BAD};
                  pv_in   = 1'b1;
                  ret_in  = S_IDLE;
                  st_in   = S_PUSH;
               end
            end else begin
               cur_in = rd_q_ff;
               if (ph_ff == PH_SEG) begin
                  st_in = S_CHK;
               end else if (rd_q_ff >= END_MARK) begin
                  pend_in = '{vo: '0, bo: '0, len: '0, tot: '0, last: 1'b1, err: ERR_SKIP};
                  pv_in   = 1'b1;
                  ret_in  = S_IDLE;
                  st_in   = S_PUSH;
               end else if (ph_ff == PH_MEAS) begin
                  len_in = len_nx;
                  if (rd_q_ff == mark_ff) begin
                     div_go = 1'b1;
                     div_a  = count_ff - 32'(TABLE_ENTRIES);
                     div_b  = 20'(len_nx);
                     st_in  = S_DIV;
                  end else if (len_nx == TW'(TABLE_ENTRIES)) begin
                     pend_in = '{vo: '0, bo: '0, len: '0, tot: '0, last: 1'b1,
                                 err: ERR_BAD};
                     pv_in   = 1'b1;
                     ret_in  = S_IDLE;
                     st_in   = S_PUSH;
                  end else begin
                     st_in = S_SKIP;
                  end
               end else begin
                  cnt_in = cnt_ff - TW'(1);
                  st_in  = S_SKIP;
               end
            end
         end
         S_SEG: begin
            if (done_ff == size_ff) begin
               if (pv_ff) begin
                  pend_in.last = 1'b1;
               end else begin
                  pend_in = '{vo: '0, bo: '0, len: '0, tot: '0, last: 1'b1, err: ERR_OK};
                  pv_in   = 1'b1;
               end
               ret_in = S_IDLE;
               st_in  = S_PUSH;
            end else if (n_ff == NW'(MAX_SEGMENTS)) begin
               pend_in.last = 1'b1;
               pend_in.err  = ERR_TRUNC;
               ret_in       = S_IDLE;
               st_in        = S_PUSH;
            end else if (hop_ff) begin
               st_in = S_HOPW;
            end else begin
               st_in = S_CHK;
            end
         end
         S_CHK: begin
            if (cur_ff >= END_MARK) begin
               if (pv_ff) begin
                  pend_in.last = 1'b1;
               end else begin
                  pend_in = '{vo: '0, bo: '0, len: '0, tot: '0, last: 1'b1, err: ERR_OK};
                  pv_in   = 1'b1;
               end
               ret_in = S_IDLE;
               st_in  = S_PUSH;
            end else if (cur_ff < 16'd2) begin
               st_in = S_ERR2;
            end else begin
               st_in = S_ADDR;
            end
         end
         S_ADDR: begin
            mul_en = 1'b1;
            mul_a  = 32'(cur_ff - 16'd2);
            mul_b  = cs_ff;
            st_in  = S_NEW;
         end
         S_NEW: begin
            if (pv_ff) begin
               ret_in = S_NEW;
               st_in  = S_PUSH;
            end else begin
               pend_in = '{vo: base_ff + p_ff + 32'(off_ff), bo: done_ff, len: slen,
                           tot: done_ff + 32'(slen), last: 1'b0, err: ERR_OK};
               pv_in   = 1'b1;
               done_in = done_ff + 32'(slen);
               off_in  = '0;
               hop_in  = 1'b1;
               n_in    = n_ff + NW'(1);
               st_in   = S_SEG;
            end
         end
         S_ERR2: begin
            if (pv_ff) begin
               ret_in = S_ERR2;
               st_in  = S_PUSH;
            end else begin
               pend_in = '{vo: '0, bo: done_ff, len: '0, tot: done_ff, last: 1'b1,
                           err: ERR_BAD};
               pv_in   = 1'b1;
               ret_in  = S_IDLE;
               st_in   = S_PUSH;
            end
         end
         S_PUSH: begin
            if (!ov_ff || rsp_tready) begin
               push  = 1'b1;
               pv_in = 1'b0;
               st_in = ret_ff;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
      if (mul_en) begin
         p_in = prod[31:0];
      end
   end

   always_comb begin
      ov_in = ov_ff;
      if (push) begin
         ov_in = 1'b1;
      end else if (rsp_tready) begin
         ov_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[widx[AW-1:0]] <= req_tdata[27:12];
      end
      rd_q_ff <= tbl_mem[cur_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bps_ff  <= 13'd512;
         spc_ff  <= 8'd4;
         rsv_ff  <= 16'd1;
         copy_ff <= 3'd2;
         spt_ff  <= 16'd32;
         root_ff <= 16'd512;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_BPS:  bps_ff  <= csr_wdata[12:0];
            CSR_SPC:  spc_ff  <= csr_wdata[7:0];
            CSR_RSV:  rsv_ff  <= csr_wdata;
            CSR_COPY: copy_ff <= csr_wdata[2:0];
            CSR_SPT:  spt_ff  <= csr_wdata;
            CSR_ROOT: root_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= S_IDLE;
         ret_ff <= S_IDLE;
         pv_ff  <= 1'b0;
         ov_ff  <= 1'b0;
      end else begin
         st_ff  <= st_in;
         ret_ff <= ret_in;
         pv_ff  <= pv_in;
         ov_ff  <= ov_in;
      end
      ph_ff    <= ph_in;
      step_ff  <= step_in;
      cs_ff    <= cs_in;
      base_ff  <= base_in;
      p_ff     <= p_in;
      cur_ff   <= cur_in;
      pos_ff   <= pos_in;
      count_ff <= count_in;
      off_ff   <= off_in;
      cnt_ff   <= cnt_in;
      len_ff   <= len_in;
      mark_ff  <= mark_in;
      done_ff  <= done_in;
      size_ff  <= size_in;
      n_ff     <= n_in;
      hop_ff   <= hop_in;
      pend_ff  <= pend_in;
      if (push) begin
         out_ff <= pend_ff;
      end
   end

   assign req_tready = (st_ff == S_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {4'd0, out_ff.tot, out_ff.len, out_ff.bo, out_ff.vo};
   assign rsp_tuser  = out_ff.err;
   assign rsp_tlast  = out_ff.last;

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking bench for fat16_read_segment_planner: random and directed table writes,
// read requests and register settings, with results checked against a local chain planner
// depends on fat16rsp_pkg and the planner rtl
module testbench;
   import fat16rsp_pkg::*;

   localparam int TBL       = 4096;
   localparam int WIN       = 128;
   localparam int MAX_SEG   = 64;
   localparam int IDLE_MAX  = 100000;
   localparam int SETTLE    = 60;
   localparam int LONG_HOLD = 400;

   typedef enum logic [1:0] {K_WORD, K_CFG, K_PAUSE} kind_type;

   typedef struct {
      kind_type     kind;
      logic [111:0] data;
      logic         func;
      logic [2:0]   addr;
      logic [15:0]  wdata;
      int           gap;
   } req_item_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [111:0] req_tdata;
   logic [0:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [119:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we;
   logic [2:0]   csr_addr;
   logic [15:0]  csr_wdata;

   fat16_read_segment_planner u_top (.*);

   req_item_type pending[$];
   seg_type      seg_expect[$];
   logic [15:0]  chain_table[TBL];
   logic [15:0]  creg[6];
   logic [15:0]  gen_reg[6];

   bit req_taken, rsp_taken, start_hold, hold_done, burst;
   int gap_left, settle, hold_left, rsp_stall, rsp_mode_left, idle_cycles;
   int fail_count, reads_seen, writes_seen, segs_checked, cfg_writes;
   int err_seen[4];

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic int unsigned cluster_bytes(logic [15:0] r[6]);
      return clampu(r[0], 1, 4096) * clampu(r[1], 1, 128);
   endfunction

   function automatic int follow_link(inout int unsigned cur);
      if (cur >= TBL) return 2;
      cur = chain_table[cur];
      return cur >= END_MARK ? 1 : 0;
   endfunction

   function automatic int skip_chain(inout int unsigned cur, input int unsigned count);
      int unsigned lim, i, len, rem, mark;
      int e;
      lim = count < TBL ? count : TBL;
      for (i = 0; i < lim; i++) begin
         e = follow_link(cur);
         if (e != 0) return e;
      end
      if (count <= TBL) return 0;
      mark = cur;
      len = 0;
      do begin
         e = follow_link(cur);
         if (e != 0) return e;
         len++;
      end while (cur != mark && len < TBL);
      if (cur != mark) return 2;
      rem = (count - TBL) % len;
      for (i = 0; i < rem; i++) begin
         e = follow_link(cur);
         if (e != 0) return e;
      end
      return 0;
   endfunction

   function automatic seg_type make_seg(longint unsigned vo, longint unsigned bo,
                                        longint unsigned len, longint unsigned tot,
                                        logic [1:0] err);
      seg_type s;
      s.vo = vo[31:0];
      s.bo = bo[31:0];
      s.len = len[19:0];
      s.tot = tot[31:0];
      s.last = 1'b0;
      s.err = err;
      return s;
   endfunction

   task automatic plan_read(logic [15:0] sc, logic [31:0] pos, logic [31:0] size);
      int unsigned bps, cs, cur, cnt, off;
      longint unsigned base, done, len, sz;
      int e;
      bit need_hop;
      seg_type segs[$];
      bps = clampu(creg[0], 1, 4096);
      cs = cluster_bytes(creg);
      base = longint'(creg[2]) * bps + longint'(clampu(creg[3], 1, 4))
             * clampu(creg[4], 1, 65535) * bps + longint'(creg[5]) * 32;
      cur = sc;
      cnt = pos / cs;
      off = pos % cs;
      sz = size;
      done = 0;
      need_hop = 0;
      e = skip_chain(cur, cnt);
      if (e != 0) begin
         segs.push_back(make_seg(0, 0, 0, 0, 2'(e)));
      end else begin
         while (done < sz) begin
            if (segs.size() == MAX_SEG) begin
               segs[$].err = ERR_TRUNC;
               break;
            end
            if (need_hop && follow_link(cur) == 2) begin
               segs.push_back(make_seg(0, done, 0, done, ERR_BAD));
               break;
            end
            if (cur >= END_MARK) break;
            if (cur < 2) begin
               segs.push_back(make_seg(0, done, 0, done, ERR_BAD));
               break;
            end
            len = cs - off;
            if (len > sz - done) len = sz - done;
            segs.push_back(make_seg(base + longint'(cur - 2) * cs + off, done, len,
                                    done + len, ERR_OK));
            done += len;
            off = 0;
            need_hop = 1;
         end
         if (segs.size() == 0) segs.push_back(make_seg(0, 0, 0, 0, ERR_OK));
      end
      segs[$].last = 1'b1;
      foreach (segs[i]) seg_expect.push_back(segs[i]);
   endtask

   // stimulus builders
   task automatic add_word(logic func, logic [11:0] idx, logic [15:0] val, logic [15:0] sc,
                           logic [31:0] pos, logic [31:0] cnt);
      req_item_type it;
      if ($urandom_range(0, 29) == 0) burst = ~burst;
      it.kind = K_WORD;
      it.func = func;
      it.data = {4'b0, cnt, pos, sc, val, idx};
      it.gap = burst ? 0 : $urandom_range(0, 10);
      pending.push_back(it);
   endtask

   task automatic add_cfg(logic [2:0] addr, logic [15:0] data);
      req_item_type it;
      it.kind = K_CFG;
      it.addr = addr;
      it.wdata = data;
      it.gap = 0;
      pending.push_back(it);
      gen_reg[addr] = data;
   endtask

   task automatic add_pause();
      req_item_type it;
      it.kind = K_PAUSE;
      it.gap = 0;
      pending.push_back(it);
   endtask

   task automatic set_all(logic [15:0] bps, logic [15:0] spc, logic [15:0] rsv,
                          logic [15:0] cop, logic [15:0] spt, logic [15:0] root);
      add_cfg(CSR_BPS, bps);
      add_cfg(CSR_SPC, spc);
      add_cfg(CSR_RSV, rsv);
      add_cfg(CSR_COPY, cop);
      add_cfg(CSR_SPT, spt);
      add_cfg(CSR_ROOT, root);
   endtask

   // links stay inside the written window, or point past the table or at an end mark
   function automatic logic [15:0] rand_link(int unsigned idx);
      int r;
      r = $urandom_range(0, 99);
      if (r < 90) return idx < WIN - 1 ? 16'(idx + 1) : END_MARK;
      if (r < 93) return 16'(END_MARK + $urandom_range(0, 8));
      if (r < 96) return 16'($urandom_range(2, WIN - 1));
      if (r < 97) return 16'($urandom_range(0, 1));
      if (r < 98) return 16'($urandom_range(TBL, 16'hfff6));
      return 16'($urandom_range(TBL, 16'hffff));
   endfunction

   task automatic add_write(int unsigned idx, logic [15:0] val);
      add_word(FUNC_WRITE, 12'(idx), val, 16'($urandom), $urandom, $urandom);
   endtask

   task automatic add_read(logic [15:0] sc, logic [31:0] pos, logic [31:0] cnt);
      add_word(FUNC_READ, 12'($urandom), 16'($urandom), sc, pos, cnt);
   endtask

   task automatic random_phase(int items);
      longint unsigned cs, p, s;
      int r;
      logic [15:0] sc;
      cs = cluster_bytes(gen_reg);
      repeat (items) begin
         if ($urandom_range(0, 99) < 35) begin
            r = $urandom_range(0, WIN - 1);
            add_write(r, $urandom_range(0, 3) == 0 ? 16'($urandom_range(2, WIN - 1))
                                                    : rand_link(r));
         end else begin
            r = $urandom_range(0, 99);
            if (r < 75) sc = 16'($urandom_range(2, WIN - 1));
            else if (r < 83) sc = 16'($urandom_range(0, 1));
            else if (r < 91) sc = 16'($urandom_range(16'hfff7, 16'hffff));
            else sc = 16'($urandom_range(TBL, 16'hffff));
            r = $urandom_range(0, 99);
            if (r < 60) p = $urandom_range(0, 32'(4 * cs - 1));
            else if (r < 85) p = $urandom_range(0, 63) * cs + $urandom_range(0, 32'(cs - 1));
            else if (r < 95) p = $urandom_range(4090, 5000) * cs;
            else p = $urandom;
            r = $urandom_range(0, 99);
            if (r < 10) s = 0;
            else if (r < 60) s = $urandom_range(1, 32'(4 * cs));
            else if (r < 80) s = $urandom_range(1, 70) * cs + $urandom_range(0, 99);
            else if (r < 90) s = $urandom_range(1, 8) * cs;
            else s = $urandom;
            add_read(sc, p[31:0], s[31:0]);
         end
      end
   endtask

   // sender
   always @(negedge clock) begin
      req_item_type it;
      if (!reset) begin
         if (csr_we) begin
            csr_we <= 1'b0;
         end else if (req_tvalid && !req_taken) begin
         end else begin
            req_taken = 0;
            if (gap_left > 0) begin
               req_tvalid <= 1'b0;
               gap_left--;
            end else if (pending.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (pending[0].kind == K_WORD) begin
               it = pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= it.data;
               req_tuser <= it.func;
               gap_left = it.gap;
               settle = 0;
            end else begin
               req_tvalid <= 1'b0;
               settle = seg_expect.size() == 0 ? settle + 1 : 0;
               if (settle >= SETTLE) begin
                  it = pending.pop_front();
                  settle = 0;
                  if (it.kind == K_CFG) begin
                     csr_we <= 1'b1;
                     csr_addr <= it.addr;
                     csr_wdata <= it.wdata;
                  end
               end
            end
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (start_hold && !hold_done) begin
            hold_done = 1;
            hold_left = LONG_HOLD;
            rsp_tready <= 1'b0;
         end else if (rsp_taken) begin
            rsp_taken = 0;
            if (rsp_mode_left == 0) rsp_mode_left = $urandom_range(1, 60);
            rsp_mode_left--;
            rsp_stall = (rsp_mode_left % 2 == 0) ? $urandom_range(0, 10) : 0;
            rsp_tready <= rsp_stall == 0;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor, checker and watchdog
   always @(posedge clock) begin
      seg_type got, want;
      if (!reset) begin
         idle_cycles++;
         if (csr_we) begin
            idle_cycles = 0;
            cfg_writes++;
            case (csr_addr)
               CSR_BPS:  creg[0] = csr_wdata & 16'h1fff;
               CSR_SPC:  creg[1] = csr_wdata & 16'h00ff;
               CSR_RSV:  creg[2] = csr_wdata;
               CSR_COPY: creg[3] = csr_wdata & 16'h0007;
               CSR_SPT:  creg[4] = csr_wdata;
               CSR_ROOT: creg[5] = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            idle_cycles = 0;
            req_taken = 1;
            if (req_tuser[0] == FUNC_WRITE) begin
               writes_seen++;
               chain_table[req_tdata[11:0]] = req_tdata[27:12];
            end else begin
               reads_seen++;
               if (reads_seen == 150) start_hold = 1;
               plan_read(req_tdata[43:28], req_tdata[75:44], req_tdata[107:76]);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            idle_cycles = 0;
            rsp_taken = 1;
            got.vo = rsp_tdata[31:0];
            got.bo = rsp_tdata[63:32];
            got.len = rsp_tdata[83:64];
            got.tot = rsp_tdata[115:84];
            got.last = rsp_tlast;
            got.err = rsp_tuser;
            segs_checked++;
            err_seen[got.err]++;
            if (seg_expect.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected segment vo=%h bo=%h len=%h tot=%h last=%b err=%0d",
                        $time, got.vo, got.bo, got.len, got.tot, got.last, got.err);
            end else begin
               want = seg_expect.pop_front();
               if (got != want) begin
                  fail_count++;
                  $display("%0t: segment mismatch", $time);
                  $display("   expected vo=%h bo=%h len=%h tot=%h last=%b err=%0d",
                           want.vo, want.bo, want.len, want.tot, want.last, want.err);
                  $display("   actual   vo=%h bo=%h len=%h tot=%h last=%b err=%0d",
                           got.vo, got.bo, got.len, got.tot, got.last, got.err);
               end
            end
         end
         if (idle_cycles >= IDLE_MAX) begin
            $display("%0t: no progress for %0d cycles", $time, IDLE_MAX);
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_addr = CSR_BPS;
      csr_wdata = '0;
      creg = '{16'd512, 16'd4, 16'd1, 16'd2, 16'd32, 16'd512};
      gen_reg = creg;
      burst = 0;

      // low window of the table first; walks leave it only past the table or to 4095
      for (int i = 0; i < WIN; i++) add_write(i, rand_link(i));

      // directed: default geometry, cluster of 2048 bytes
      add_write(10, 16'd11);
      add_write(11, 16'd12);
      add_write(12, 16'hffff);
      add_write(20, 16'd21);
      add_write(21, 16'd20);
      add_write(30, 16'd30);
      add_write(40, 16'd1);
      add_write(50, 16'd4095);
      add_write(4095, 16'hfff7);
      add_read(16'd10, 32'd0, 32'd0);
      add_read(16'hffff, 32'd0, 32'd100);
      add_read(16'd0, 32'd0, 32'd100);
      add_read(16'd10, 32'd0, 32'd1);
      add_read(16'd10, 32'd100, 32'd5000);
      add_read(16'd10, 32'd2048 * 5, 32'd10);
      add_read(16'd5000, 32'd0, 32'd10000);
      add_read(16'd5000, 32'd4096, 32'd1);
      add_read(16'd20, 32'd2048 * 5001 + 7, 32'd6000);
      add_read(16'd30, 32'd3, 32'hffffffff);
      add_read(16'd40, 32'd0, 32'd9000);
      add_read(16'd50, 32'hffffffff, 32'hffffffff);
      add_read(16'd50, 32'd0, 32'd2048 * 2);
      add_pause();

      random_phase(80);
      set_all(16'd1, 16'd1, 16'd0, 16'd1, 16'd1, 16'd0);
      random_phase(80);
      add_pause();
      set_all(16'd4096, 16'd128, 16'hffff, 16'd4, 16'hffff, 16'hffff);
      random_phase(60);
      set_all(16'd0, 16'd0, 16'd3, 16'd0, 16'd0, 16'd7);
      random_phase(50);
      set_all(16'h1fff, 16'hff, 16'd9, 16'd7, 16'd5, 16'd1);
      random_phase(30);
      set_all(16'($urandom_range(1, 64)), 16'($urandom_range(1, 8)), 16'($urandom),
              16'($urandom_range(1, 4)), 16'($urandom), 16'($urandom));
      random_phase(60);

      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      wait (pending.size() == 0 && !req_tvalid && !csr_we && seg_expect.size() == 0);
      repeat (200) @(posedge clock);
      $display("covered %0d reads, %0d table writes, %0d register writes, %0d segments",
               reads_seen, writes_seen, cfg_writes, segs_checked);
      $display("error codes seen: ok %0d, skip end %0d, bad cluster %0d, truncated %0d",
               err_seen[0], err_seen[1], err_seen[2], err_seen[3]);
      if (fail_count == 0 && seg_expect.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
